// File: rtl/core/omt_pkg.sv
`timescale 1ns / 1ps

package omt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 5;
  localparam int CNTO_W   = 5;
  localparam int STAT_W   = 2;
  localparam int OUT_W    = 16;

  localparam logic [IDX_W:0]   CapSum = (IDX_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] IdxLast = IDX_W'(CAPACITY - 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_SEARCH = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
    logic [CNTO_W-1:0] entry_count;
    logic              is_empty;
    status_e           status;
  } omt_res_t;

  // physical slot of a logical offset from the front
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= CapSum) begin
      s = s - CapSum;
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] dec_idx(input logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] r;
    if (base == '0) begin
      r = IdxLast;
    end else begin
      r = base - IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/omt_ram.sv
`timescale 1ns / 1ps

module omt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/omt_ctrl.sv
`timescale 1ns / 1ps

module omt_ctrl import omt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  func_e             in_func_i,
  input  logic [DATA_W-1:0] in_value_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output omt_res_t          res_o,
  output logic              ram_we_o,
  output logic [IDX_W-1:0]  ram_waddr_o,
  output logic [DATA_W-1:0] ram_wdata_o,
  output logic              ram_re_o,
  output logic [IDX_W-1:0]  ram_raddr_o,
  input  logic [DATA_W-1:0] ram_rdata_i
);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  func_e             func_q, func_d;
  logic [DATA_W-1:0] value_q, value_d;
  omt_res_t          res_q, res_d;

  logic             match;
  logic             scan_last;
  logic [CNT_W-1:0] count_dec;

  assign match     = (ram_rdata_i == value_q);
  assign scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign count_dec = count_q - CNT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_func_i)
            FUNC_REMOVE, FUNC_SEARCH: state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
            default:                  state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_d = (func_q == FUNC_REMOVE && idx_q != '0) ? ST_SHIFT : ST_DONE;
        end else if (scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (idx_q == IDX_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    func_d      = func_q;
    value_d     = value_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = head_q;
    ram_wdata_o = value_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = head_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d            = in_func_i;
          value_d           = in_value_i;
          idx_d             = '0;
          res_d.found       = 1'b0;
          res_d.position    = '0;
          res_d.entry_count = CNTO_W'(count_q);
          res_d.is_empty    = (count_q == '0);
          res_d.status      = STAT_OK;
          unique case (in_func_i)
            FUNC_ADD: begin
              if (count_q == CapCnt) begin
                res_d.status = STAT_FULL;
              end else begin
                ram_we_o          = 1'b1;
                ram_waddr_o       = dec_idx(head_q);
                ram_wdata_o       = in_value_i;
                head_d            = dec_idx(head_q);
                count_d           = count_q + CNT_W'(1);
                res_d.entry_count = CNTO_W'(count_q + CNT_W'(1));
                res_d.is_empty    = 1'b0;
              end
            end
            FUNC_REMOVE: begin
              if (count_q == '0) begin
                res_d.status = STAT_ABSENT;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = head_q;
              end
            end
            FUNC_SEARCH: begin
              if (count_q != '0) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = head_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (match) begin
          res_d.found    = 1'b1;
          res_d.position = POS_W'(CNT_W'(idx_q) + CNT_W'(1));
          if (func_q == FUNC_REMOVE) begin
            if (idx_q == '0) begin
              // front entry: just advance the head
              head_d            = phys_idx(head_q, IDX_W'(1));
              count_d           = count_dec;
              res_d.entry_count = CNTO_W'(count_dec);
              res_d.is_empty    = (count_dec == '0);
            end else begin
              // idx_q now marks the slot to fill from the one in front
              ram_re_o    = 1'b1;
              ram_raddr_o = phys_idx(head_q, idx_q - IDX_W'(1));
            end
          end
        end else if (scan_last) begin
          if (func_q == FUNC_REMOVE) begin
            res_d.status = STAT_ABSENT;
          end
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = phys_idx(head_q, idx_q + IDX_W'(1));
          idx_d       = idx_q + IDX_W'(1);
        end
      end
      ST_SHIFT: begin
        // move the entry in front back by one slot, toward the hole
        ram_we_o    = 1'b1;
        ram_waddr_o = phys_idx(head_q, idx_q);
        ram_wdata_o = ram_rdata_i;
        if (idx_q == IDX_W'(1)) begin
          head_d            = phys_idx(head_q, IDX_W'(1));
          count_d           = count_dec;
          res_d.entry_count = CNTO_W'(count_dec);
          res_d.is_empty    = (count_dec == '0);
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = phys_idx(head_q, idx_q - IDX_W'(2));
          idx_d       = idx_q - IDX_W'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    func_q  <= func_d;
    value_q <= value_d;
    res_q   <= res_d;
  end

endmodule

// File: rtl/core/ordered_multiset_table_core.sv
`timescale 1ns / 1ps
// channel | direction | handshake                     | contents
// s_axis  | in        | s_axis_tvalid_i/s_axis_tready_o | tdata: value, tuser: func
// m_axis  | out       | m_axis_tvalid_o/m_axis_tready_i | tdata: found .. status
//
// one word at a time: add, refused add and unused func go straight to the
// result; search scans from the front up to the match (through the whole count
// on a miss), and remove then closes the gap, one entry per cycle
// the entries live in a single ring memory with a registered read; the head
// pointer moves on add, so no shift is needed there
// reset empties the table at once (count and head clear, no memory sweep)
// a result sits in the output register; the next word is taken only once
// the previous result has moved into that register, so a stalled receiver
// holds the input off as well
module ordered_multiset_table_core import omt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DATA_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic [FUNC_W-1:0] s_axis_tuser_i,  // [1:0] func
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_W-1:0]  m_axis_tdata_o   // [0] found, [5:1] position,
                                             // [10:6] entry_count, [11] is_empty,
                                             // [13:12] status, [15:14] zero
);

  logic              res_valid;
  logic              res_ready;
  omt_res_t          res;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  out_data_q, out_data_d;

  omt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_func_i   (func_e'(s_axis_tuser_i)),
    .in_value_i  (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  omt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = OUT_W'({res.status, res.is_empty, res.entry_count,
                            res.position, res.found});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import omt_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;  // unused selector
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
    logic [CNTO_W-1:0] entry_count;
    logic              is_empty;
    logic [STAT_W-1:0] status;
  } bag_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [DATA_W-1:0] s_axis_tdata_i = '0;  // [31:0] value
  logic [FUNC_W-1:0] s_axis_tuser_i = '0;  // [1:0] func
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata_o;      // [0] found, [5:1] position, [10:6] entry_count,
                                          // [11] is_empty, [13:12] status

  // bag contents as the block should hold them, front at index 0
  logic [DATA_W-1:0] bag_vals [CAPACITY];
  int                bag_cnt = 0;
  bag_res_t          expected_q [$];
  int                mismatch_cnt = 0;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  logic fill_mode = 1'b1;

  ordered_multiset_table_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // applies one operation to the bag and returns the result it should give
  function automatic bag_res_t bag_apply(input logic [FUNC_W-1:0] fn,
                                         input logic [DATA_W-1:0] val);
    bag_res_t r;
    int hit;
    int i;
    r = '0;
    hit = -1;
    if (fn == FUNC_REMOVE || fn == FUNC_SEARCH) begin
      for (i = bag_cnt - 1; i >= 0; i--) begin
        if (bag_vals[i] == val) hit = i;
      end
    end
    if (fn == FUNC_ADD) begin
      if (bag_cnt >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        for (i = bag_cnt; i > 0; i--) bag_vals[i] = bag_vals[i-1];
        bag_vals[0] = val;
        bag_cnt++;
      end
    end else if (fn == FUNC_REMOVE) begin
      if (hit >= 0) begin
        r.found = 1'b1;
        r.position = POS_W'(hit + 1);
        for (i = hit; i + 1 < bag_cnt; i++) bag_vals[i] = bag_vals[i+1];
        bag_cnt--;
      end else begin
        r.status = STAT_ABSENT;
      end
    end else if (fn == FUNC_SEARCH) begin
      if (hit >= 0) begin
        r.found = 1'b1;
        r.position = POS_W'(hit + 1);
      end
    end
    r.entry_count = CNTO_W'(bag_cnt);
    r.is_empty = (bag_cnt == 0);
    return r;
  endfunction

  function automatic int idle_gap();
    if (send_idle_pct == 0 || $urandom_range(99) >= send_idle_pct) return 0;
    if ($urandom_range(29) == 0) return $urandom_range(60, 15);
    return $urandom_range(3, 1);
  endfunction

  task automatic push_word(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val);
    logic rdy;
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= val;
    s_axis_tuser_i <= fn;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready_o;
      @(posedge clk_i);
    end while (!rdy);
    expected_q.push_back(bag_apply(fn, val));
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // mostly values already held or from a narrow pool so that matches are common
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 45 && bag_cnt > 0) return bag_vals[$urandom_range(bag_cnt - 1)];
    if (r < 75) return DATA_W'($urandom_range(6)) - DATA_W'(3);
    return $urandom;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    if (bag_cnt == CAPACITY) fill_mode = 1'b0;
    else if (bag_cnt == 0) fill_mode = 1'b1;
    else if ($urandom_range(59) == 0) fill_mode = ~fill_mode;
    r = $urandom_range(99);
    if (r < 5) return FUNC_NONE;
    if (r < 25) return FUNC_SEARCH;
    if (fill_mode) return (r < 75) ? FUNC_ADD : FUNC_REMOVE;
    return (r < 75) ? FUNC_REMOVE : FUNC_ADD;
  endfunction

  task automatic run_random(input int n_items);
    repeat (n_items) push_word(pick_func(), pick_value());
  endtask

  task automatic test_empty_table();
    push_word(FUNC_SEARCH, 32'h0000_0000);
    push_word(FUNC_REMOVE, 32'hffff_ffff);
    push_word(FUNC_NONE, 32'h1234_5678);
  endtask

  // fills with extremes and a duplicate, then hits full, front, back and miss
  task automatic test_full_table();
    int i;
    push_word(FUNC_ADD, 32'h8000_0000);
    push_word(FUNC_ADD, 32'h7fff_ffff);
    push_word(FUNC_ADD, 32'hffff_ffff);
    push_word(FUNC_ADD, 32'h0000_0000);
    push_word(FUNC_ADD, 32'h0000_0001);
    push_word(FUNC_ADD, 32'h7fff_ffff);
    for (i = 0; i < CAPACITY - 6; i++) push_word(FUNC_ADD, DATA_W'(100 + i));
    push_word(FUNC_ADD, 32'h5555_aaaa);
    push_word(FUNC_SEARCH, DATA_W'(100 + CAPACITY - 7));
    push_word(FUNC_SEARCH, 32'h8000_0000);
    push_word(FUNC_SEARCH, 32'h0bad_cafe);
    push_word(FUNC_NONE, 32'h0000_0000);
    push_word(FUNC_REMOVE, 32'h8000_0000);
    push_word(FUNC_REMOVE, 32'h7fff_ffff);
    push_word(FUNC_REMOVE, DATA_W'(100 + CAPACITY - 7));
  endtask

  task automatic test_random_streaming();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(300);
  endtask

  task automatic test_random_idling();
    send_idle_pct = 30;
    recv_stall_pct = 30;
    run_random(1060);
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off while words keep coming, so the input must stall
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    run_random(40);
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
      m_axis_tready_i <= 1'b0;
      if ($urandom_range(29) == 0) hold_left = $urandom_range(60, 15);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic check_word(input logic [OUT_W-1:0] w);
    bag_res_t got;
    bag_res_t exp;
    got.found = w[0];
    got.position = w[5:1];
    got.entry_count = w[10:6];
    got.is_empty = w[11];
    got.status = w[13:12];
    if (expected_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("unexpected result word %h at %0t", w, $realtime);
    end else begin
      exp = expected_q.pop_front();
      if (got !== exp) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("mismatch at %0t: exp found %b pos %0d cnt %0d empty %b st %0d, got found %b pos %0d cnt %0d empty %b st %0d",
                   $realtime, exp.found, exp.position, exp.entry_count, exp.is_empty,
                   exp.status, got.found, got.position, got.entry_count, got.is_empty,
                   got.status);
      end
    end
  endtask

  logic             res_taken;
  logic [OUT_W-1:0] res_word;

  // sample mid-cycle, commit at the edge where the word is taken
  always begin
    @(negedge clk_i);
    res_taken = m_axis_tvalid_o && m_axis_tready_i && rst_ni;
    res_word = m_axis_tdata_o;
    @(posedge clk_i);
    if (res_taken) check_word(res_word);
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_full_table();
    test_random_streaming();
    test_output_backpressure();
    test_random_idling();
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/omt_pkg.sv
rtl/core/omt_ram.sv
rtl/core/omt_ctrl.sv
rtl/core/ordered_multiset_table_core.sv
dv/testbench.sv
